// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Depends on nothing; included by the checker module rtc_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the asynchronous reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("RTC check failed");

// Implication form: when the condition holds, the consequence must hold.
`define ASSERT_IMPL(label, clk_sig, rst_n_sig, cond, cons) \
	`ASSERT_CLK(label, clk_sig, rst_n_sig, (cond) |-> (cons))

`endif

// ===== sv/rtc_pkg.sv =====
// Package for the real-time clock: types, constants and calendar helper functions.
// Used by rtc_next and by the top level; depends on nothing.
package rtc_pkg;

	localparam int UP_DAY_W   = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 80;

	localparam logic [5:0] SEC_LAST   = 6'd59;
	localparam logic [5:0] MIN_LAST   = 6'd59;
	localparam logic [4:0] HOUR_LAST  = 5'd23;
	localparam logic [3:0] MONTH_LAST = 4'd12;
	localparam logic [3:0] MONTH_FEB  = 4'd2;
	localparam logic [3:0] MONTH_APR  = 4'd4;
	localparam logic [3:0] MONTH_JUN  = 4'd6;
	localparam logic [3:0] MONTH_SEP  = 4'd9;
	localparam logic [3:0] MONTH_NOV  = 4'd11;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_SET  = 2'd1,
		REQ_DST  = 2'd2
	} req_t;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		req_t        req;
		logic [15:0] set_year;
		logic [3:0]  set_month;
		logic [4:0]  set_day;
		logic [4:0]  set_hour;
		logic [5:0]  set_minute;
		logic [5:0]  set_second;
		logic [4:0]  new_offset;
	} item_t;

	typedef struct packed {
		logic                cal_valid;
		date_t               date;
		logic [4:0]          hour;
		logic [5:0]          minute;
		logic [5:0]          second;
		logic [4:0]          dst_hours;
		logic [UP_DAY_W-1:0] up_days;
		logic [4:0]          up_hours;
		logic [5:0]          up_minutes;
		logic [5:0]          up_seconds;
	} rtc_state_t;

	localparam rtc_state_t RTC_RESET = '{
		cal_valid:  1'b0,
		date:       '{year: 16'd0, month: 4'd1, day: 5'd1},
		hour:       5'd0,
		minute:     6'd0,
		second:     6'd0,
		dst_hours:  5'd0,
		up_days:    '0,
		up_hours:   5'd0,
		up_minutes: 6'd0,
		up_seconds: 6'd0
	};

	// Unused month codes count as 31-day months.
	function automatic logic [4:0] month_len(logic [3:0] m, logic [15:0] y);
		logic [4:0] len;
		unique case (m)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			MONTH_FEB: len = (y[1:0] != 2'd0) ? 5'd28 : 5'd29;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic date_t next_day(date_t d);
		date_t n;
		n = d;
		if (d.day >= month_len(d.month, d.year)) begin
			n.day = 5'd1;
			if (d.month >= MONTH_LAST) begin
				n.month = 4'd1;
				n.year  = d.year + 16'd1;
			end else begin
				n.month = d.month + 4'd1;
			end
		end else begin
			n.day = d.day + 5'd1;
		end
		return n;
	endfunction

	function automatic date_t prev_day(date_t d);
		date_t n;
		n = d;
		if (d.day <= 5'd1) begin
			if (d.month <= 4'd1) begin
				n.month = MONTH_LAST;
				n.year  = d.year - 16'd1;
			end else begin
				n.month = d.month - 4'd1;
			end
			n.day = month_len(n.month, n.year);
		end else begin
			n.day = d.day - 5'd1;
		end
		return n;
	endfunction

endpackage

// ===== sv/rtc_next.sv =====
// Next-state logic of the real-time clock: tick, set and DST change for one beat.
// Depends on rtc_pkg.
module rtc_next (
	input  rtc_pkg::rtc_state_t cur,
	input  rtc_pkg::item_t      item,
	output rtc_pkg::rtc_state_t nxt
);
	import rtc_pkg::*;

	logic signed [7:0] hsum;
	logic signed [7:0] hmod;

	// Hour after an offset change lies in -31..62, so at most two corrections bring it into 0..23.
	always_comb begin
		hsum = $signed({3'b000, cur.hour}) + $signed({3'b000, item.new_offset})
			- $signed({3'b000, cur.dst_hours});
		priority if (hsum < -8'sd24) begin
			hmod = hsum + 8'sd48;
		end else if (hsum < 8'sd0) begin
			hmod = hsum + 8'sd24;
		end else if (hsum > 8'sd47) begin
			hmod = hsum - 8'sd48;
		end else if (hsum > 8'sd23) begin
			hmod = hsum - 8'sd24;
		end else begin
			hmod = hsum;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (item.req)
			REQ_TICK: begin
				if (cur.up_seconds < SEC_LAST) begin
					nxt.up_seconds = cur.up_seconds + 6'd1;
				end else begin
					nxt.up_seconds = 6'd0;
					if (cur.up_minutes < MIN_LAST) begin
						nxt.up_minutes = cur.up_minutes + 6'd1;
					end else begin
						nxt.up_minutes = 6'd0;
						if (cur.up_hours < HOUR_LAST) begin
							nxt.up_hours = cur.up_hours + 5'd1;
						end else begin
							nxt.up_hours = 5'd0;
							nxt.up_days  = cur.up_days + UP_DAY_W'(1);
						end
					end
				end
				if (cur.cal_valid) begin
					if (cur.second < SEC_LAST) begin
						nxt.second = cur.second + 6'd1;
					end else begin
						nxt.second = 6'd0;
						if (cur.minute < MIN_LAST) begin
							nxt.minute = cur.minute + 6'd1;
						end else begin
							nxt.minute = 6'd0;
							if (cur.hour < HOUR_LAST) begin
								nxt.hour = cur.hour + 5'd1;
							end else begin
								nxt.hour = 5'd0;
								nxt.date = next_day(cur.date);
							end
						end
					end
				end
			end
			REQ_SET: begin
				nxt.date.year  = item.set_year;
				nxt.date.month = item.set_month;
				nxt.date.day   = item.set_day;
				nxt.hour       = item.set_hour;
				nxt.minute     = item.set_minute;
				nxt.second     = item.set_second;
				nxt.dst_hours  = item.new_offset;
				nxt.cal_valid  = 1'b1;
			end
			REQ_DST: begin
				if (cur.cal_valid) begin
					nxt.hour      = hmod[4:0];
					nxt.dst_hours = item.new_offset;
					if (hsum < 8'sd0) begin
						nxt.date = prev_day(cur.date);
					end else if (hsum > 8'sd23) begin
						nxt.date = next_day(cur.date);
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== sv/calendar_rtc_with_dst_and_uptime_unit.sv =====
// Top level of the real-time clock with calendar, DST offset and uptime counter.
// Depends on rtc_pkg and rtc_next.

// The block takes one request beat per cycle at sustained rate while result beats are taken,
// and answers every request with one result beat, holding the calendar and uptime as they stand
// after that request. A request is captured in an input register, then a single pass of
// second/minute/hour/day/month/year rollover logic updates the clock registers, which drive the
// result beat directly; when the result is not taken, one further request waits in the input
// register and then input ready drops. Request kinds: tick, set (loads date, time and DST offset
// and marks the calendar valid), DST change (ignored until the calendar is valid); code 3 leaves
// everything unchanged. Set values are not range checked.
module calendar_rtc_with_dst_and_uptime_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// set_year, set_month, set_day, set_hour, set_minute, set_second, new_offset, pad
	input  logic [rtc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// req_type
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// year, month, day, hour, minute, second, up_days, up_hours, up_minutes, up_seconds, pad
	output logic [rtc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// calendar_valid
	output logic [0:0]                        m_axis_tuser
);
	import rtc_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	rtc_state_t state_q;
	rtc_state_t state_nxt;
	logic       out_valid_q;
	logic       advance;
	logic       fire;

	rtc_next u_next (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt)
	);

	// The clock registers double as the result register, so they only move once the beat is taken.
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= RTC_RESET;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.req        <= req_t'(s_axis_tuser);
			item_s1.set_year   <= s_axis_tdata[15:0];
			item_s1.set_month  <= s_axis_tdata[19:16];
			item_s1.set_day    <= s_axis_tdata[24:20];
			item_s1.set_hour   <= s_axis_tdata[29:25];
			item_s1.set_minute <= s_axis_tdata[35:30];
			item_s1.set_second <= s_axis_tdata[41:36];
			item_s1.new_offset <= s_axis_tdata[46:42];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = state_q.cal_valid;
	assign m_axis_tdata  = {
		5'd0,
		state_q.up_seconds,
		state_q.up_minutes,
		state_q.up_hours,
		16'(state_q.up_days),
		state_q.second,
		state_q.minute,
		state_q.hour,
		state_q.date.day,
		state_q.date.month,
		state_q.date.year
	};

endmodule

// ===== sv/rtc_chk.sv =====
// Port-level checker for the real-time clock top level, with its bind statement.
// Depends on rtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rtc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [0:0]                     m_axis_tuser
);
	import rtc_pkg::*;

	logic       out_stall;
	logic [5:0] up_sec;
	logic [5:0] up_min;
	logic [4:0] up_hr;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign up_sec    = m_axis_tdata[74:69];
	assign up_min    = m_axis_tdata[68:63];
	assign up_hr     = m_axis_tdata[62:58];

	// A stalled result beat keeps its payload.
	`ASSERT_IMPL(a_out_hold, clk, arst_n, out_stall,
		##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

	// Input back-pressure only ever comes from a stalled result.
	`ASSERT_IMPL(a_ready_cause, clk, arst_n, !s_axis_tready, out_stall)

	// Once the calendar has been set it never becomes unset.
	`ASSERT_IMPL(a_valid_sticky, clk, arst_n, m_axis_tuser[0], ##1 m_axis_tuser[0])

	// Uptime parts of every valid result beat stay inside their ranges.
	`ASSERT_IMPL(a_uptime_range, clk, arst_n, m_axis_tvalid,
		(up_sec <= SEC_LAST) && (up_min <= MIN_LAST) && (up_hr <= HOUR_LAST))

endmodule

bind calendar_rtc_with_dst_and_uptime_unit rtc_chk u_rtc_chk (.*);

// ===== test/rtc_tracker_pkg.sv =====
// Scoreboard for the real-time clock testbench: predicts the status after every request beat
// and checks result beats against it. Depends on rtc_pkg for the request codes and widths.
`timescale 1ns / 1ps

package rtc_tracker_pkg;

	import rtc_pkg::*;

	// Request code 3 has no name in the design package; the block leaves everything unchanged.
	localparam logic [1:0] REQ_NOP = 2'd3;

	typedef struct {
		bit                cal_set;
		bit [15:0]         year;
		bit [3:0]          month;
		bit [4:0]          day;
		bit [4:0]          hour;
		bit [5:0]          minute;
		bit [5:0]          second;
		bit [UP_DAY_W-1:0] up_days;
		bit [4:0]          up_hours;
		bit [5:0]          up_minutes;
		bit [5:0]          up_seconds;
	} clock_status_t;

	class rtc_tracker;
		clock_status_t     pending_status[$];
		int unsigned       mismatches = 0;

		bit                cal_set = 1'b0;
		bit [15:0]         cal_year = 16'd0;
		bit [3:0]          cal_month = 4'd1;
		bit [4:0]          cal_day = 5'd1;
		bit [4:0]          cal_hour = 5'd0;
		bit [5:0]          cal_minute = 6'd0;
		bit [5:0]          cal_second = 6'd0;
		bit [4:0]          dst_offset = 5'd0;
		bit [UP_DAY_W-1:0] up_d = '0;
		bit [4:0]          up_h = 5'd0;
		bit [5:0]          up_m = 6'd0;
		bit [5:0]          up_s = 6'd0;

		function bit [4:0] month_days(bit [3:0] m, bit [15:0] y);
			case (m)
				MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
				MONTH_FEB: return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
				default: return 5'd31;
			endcase
		endfunction

		// Month codes at or above December wrap to January of the following year.
		function void advance_day();
			if (cal_day >= month_days(cal_month, cal_year)) begin
				cal_day = 5'd1;
				if (cal_month >= 4'd12) begin
					cal_month = 4'd1;
					cal_year++;
				end else begin
					cal_month++;
				end
			end else begin
				cal_day++;
			end
		endfunction

		function void note_request(logic [1:0] kind, logic [47:0] data);
			int h;
			int r;
			bit [4:0] shift;
			clock_status_t now;
			shift = data[46:42];
			case (kind)
				REQ_TICK: begin
					if (up_s < 6'd59) begin
						up_s++;
					end else begin
						up_s = 6'd0;
						if (up_m < 6'd59) begin
							up_m++;
						end else begin
							up_m = 6'd0;
							if (up_h < 5'd23) begin
								up_h++;
							end else begin
								up_h = 5'd0;
								up_d++;
							end
						end
					end
					// Out-of-range time fields roll over to zero at their next increment.
					if (cal_set) begin
						if (cal_second < 6'd59) begin
							cal_second++;
						end else begin
							cal_second = 6'd0;
							if (cal_minute < 6'd59) begin
								cal_minute++;
							end else begin
								cal_minute = 6'd0;
								if (cal_hour < 5'd23) begin
									cal_hour++;
								end else begin
									cal_hour = 5'd0;
									advance_day();
								end
							end
						end
					end
				end
				REQ_SET: begin
					cal_year = data[15:0];
					cal_month = data[19:16];
					cal_day = data[24:20];
					cal_hour = data[29:25];
					cal_minute = data[35:30];
					cal_second = data[41:36];
					dst_offset = shift;
					cal_set = 1'b1;
				end
				REQ_DST: begin
					// The offset is not even stored while the calendar is unset.
					if (cal_set) begin
						h = int'(cal_hour) + int'(shift) - int'(dst_offset);
						r = h % 24;
						if (r < 0)
							r += 24;
						cal_hour = r[4:0];
						if (h < 0) begin
							if (cal_day <= 5'd1) begin
								if (cal_month <= 4'd1) begin
									cal_month = 4'd12;
									cal_year--;
								end else begin
									cal_month--;
								end
								cal_day = month_days(cal_month, cal_year);
							end else begin
								cal_day--;
							end
						end else if (h > 23) begin
							advance_day();
						end
						dst_offset = shift;
					end
				end
				default: begin
				end
			endcase
			now.cal_set = cal_set;
			now.year = cal_year;
			now.month = cal_month;
			now.day = cal_day;
			now.hour = cal_hour;
			now.minute = cal_minute;
			now.second = cal_second;
			now.up_days = up_d;
			now.up_hours = up_h;
			now.up_minutes = up_m;
			now.up_seconds = up_s;
			pending_status.push_back(now);
		endfunction

		task report_mismatch(string what, logic [15:0] got, bit [15:0] want);
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
			mismatches++;
		endtask

		task check_field(string what, logic [15:0] got, bit [15:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		task check_status(logic [79:0] data, logic valid_flag);
			clock_status_t want;
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected result beat", 16'd0, 16'd0);
				return;
			end
			want = pending_status.pop_front();
			check_field("calendar_valid", 16'(valid_flag), 16'(want.cal_set));
			check_field("year", data[15:0], want.year);
			check_field("month", 16'(data[19:16]), 16'(want.month));
			check_field("day", 16'(data[24:20]), 16'(want.day));
			check_field("hour", 16'(data[29:25]), 16'(want.hour));
			check_field("minute", 16'(data[35:30]), 16'(want.minute));
			check_field("second", 16'(data[41:36]), 16'(want.second));
			check_field("up_days", data[57:42], 16'(want.up_days));
			check_field("up_hours", 16'(data[62:58]), 16'(want.up_hours));
			check_field("up_minutes", 16'(data[68:63]), 16'(want.up_minutes));
			check_field("up_seconds", 16'(data[74:69]), 16'(want.up_seconds));
		endtask
	endclass

endpackage

// ===== test/tb_calendar_rtc_with_dst_and_uptime_unit.sv =====
// Testbench for the real-time clock: directed calendar and DST corner cases, a run of
// back-to-back ticks across uptime minute carries, then random requests. Depends on rtc_pkg,
// rtc_tracker_pkg and the RTL of calendar_rtc_with_dst_and_uptime_unit.
`timescale 1ns / 1ps

module tb_calendar_rtc_with_dst_and_uptime_unit;

	import rtc_pkg::*;
	import rtc_tracker_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int TICK_RUN = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// set_year, set_month, set_day, set_hour, set_minute, set_second, new_offset, pad
	logic [47:0] s_axis_tdata = '0;
	// req_type
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// year, month, day, hour, minute, second, up_days, up_hours, up_minutes, up_seconds, pad
	logic [79:0] m_axis_tdata;
	// calendar_valid
	logic [0:0]  m_axis_tuser;

	rtc_tracker tracker = new();
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int out_hold = 0;
	int results_taken = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	calendar_rtc_with_dst_and_uptime_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results are checked before the request of the same edge is noted; with the input register and
	// the clock registers between them the two can never belong to each other.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				tracker.check_status(m_axis_tdata, m_axis_tuser[0]);
				results_taken++;
			end
			if (s_axis_tvalid && s_axis_tready)
				tracker.note_request(s_axis_tuser, s_axis_tdata);
		end
	end

	// A fresh wait is drawn after every result beat that was taken; it is zero while recv_idle is clear.
	always @(negedge clk) begin
		if (results_seen != results_taken) begin
			results_seen = results_taken;
			out_hold = recv_idle ? $urandom_range(0, 4) : 0;
		end
		if (out_hold > 0) begin
			m_axis_tready <= 1'b0;
			out_hold--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Called at a falling edge and returns at the falling edge after the beat is taken.
	task automatic send(input logic [1:0] kind, input logic [15:0] y, input logic [3:0] mo,
		input logic [4:0] d, input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s,
		input logic [4:0] sh);
		int gap;
		gap = send_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {1'b0, sh, s, mi, h, d, mo, y};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		int pick;
		logic [4:0] sh;
		pick = $urandom_range(0, 99);
		sh = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
		if (pick < 55) begin
			// Tick beats carry random, ignored payload.
			send(REQ_TICK, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
				6'($urandom), 6'($urandom), 5'($urandom));
		end else if (pick < 70) begin
			if ($urandom_range(0, 9) == 0) begin
				send(REQ_SET, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
					6'($urandom), 6'($urandom), 5'($urandom));
			end else begin
				// Mostly land close to a month end so ticks and DST moves cross it.
				send(REQ_SET, 16'($urandom), 4'($urandom_range(1, 12)),
					$urandom_range(0, 1) ? 5'($urandom_range(28, 31)) : 5'($urandom_range(1, 31)),
					$urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23)),
					$urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59)),
					6'($urandom_range(50, 59)), sh);
			end
		end else if (pick < 90) begin
			send(REQ_DST, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
				6'($urandom), 6'($urandom), sh);
		end else begin
			send(REQ_NOP, 16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
				6'($urandom), 6'($urandom), 5'($urandom));
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Before the calendar is set: uptime only, DST change ignored, unknown code.
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd7);
		send(REQ_NOP, 16'hffff, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 5'd31);
		// Year, leap-day, plain February, 30-day month and 16-bit year rollovers.
		send(REQ_SET, 16'd2023, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 5'd0);
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_SET, 16'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 5'd2);
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_SET, 16'd2023, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 5'd0);
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_SET, 16'd2024, 4'd4, 5'd30, 5'd23, 6'd59, 6'd59, 5'd0);
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_SET, 16'hffff, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 5'd0);
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		// DST forward into the next month and backward into a leap day and the previous year.
		send(REQ_SET, 16'd2024, 4'd1, 5'd31, 5'd23, 6'd0, 6'd0, 5'd0);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd5);
		send(REQ_SET, 16'd2024, 4'd3, 5'd1, 5'd1, 6'd0, 6'd0, 5'd10);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_SET, 16'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 5'd1);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		// Every field at its top, then a large backward DST move with a day borrow.
		send(REQ_SET, 16'hffff, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 5'd31);
		send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		// Zero month and day codes, forward and backward, then a forward move from the last hour of a day.
		send(REQ_SET, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd31);
		send(REQ_SET, 16'd100, 4'd0, 5'd0, 5'd2, 6'd0, 6'd0, 5'd5);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);
		send(REQ_SET, 16'd2024, 4'd6, 5'd15, 5'd23, 6'd30, 6'd0, 5'd0);
		send(REQ_DST, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd23);
		send(REQ_NOP, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);

		// Back-to-back ticks carry uptime seconds into minutes twice.
		send_idle = 1'b0;
		recv_idle = 1'b0;
		repeat (TICK_RUN)
			send(REQ_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 5'd0);

		for (int chunk = 0; chunk < 12; chunk++) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			repeat (50)
				send_random();
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rtc_pkg.sv
sv/rtc_next.sv
sv/calendar_rtc_with_dst_and_uptime_unit.sv
sv/rtc_chk.sv
test/rtc_tracker_pkg.sv
test/tb_calendar_rtc_with_dst_and_uptime_unit.sv
